FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Holds the command and status codes and the control bundle that goes to every
// cell of the queue chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 7;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SCAN   = 2'd2
   } cmd_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Operation broadcast to all cells.
   typedef struct packed {
      logic               ins;
      logic               rem;
      logic               scan;
      logic [KEY_W-1:0]   key;
   } ctl_type;

endpackage

`default_nettype wire

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key slot. On insert it keeps its key, takes the key of its left
// neighbor or takes the new key; on remove it takes the key of its right
// neighbor; on scan it registers whether it holds the searched key.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire spq_pkg::ctl_type            ctl,
   input  wire logic [spq_pkg::KEY_W-1:0]   left_key,
   input  wire logic                        left_valid,
   input  wire logic                        left_take,
   input  wire logic [spq_pkg::KEY_W-1:0]   right_key,
   input  wire logic                        right_valid,
   output logic [spq_pkg::KEY_W-1:0]        key_ff,
   output logic                             valid_ff,
   output logic                             take,
   output logic                             match_ff
);
   import spq_pkg::*;

   logic [KEY_W-1:0] key_in;
   logic             valid_in;
   logic             match_in;

   // The new key belongs at or before this slot when the slot is empty or
   // holds a key that is not smaller than the new one.
   assign take = !valid_ff || ($signed(key_ff) >= $signed(ctl.key));

   // Next slot contents.
   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      match_in = 1'b0;
      priority if (ctl.ins) begin
         if (take) begin
            key_in = left_take ? left_key : ctl.key;
         end
         valid_in = valid_ff | left_valid;
      end else if (ctl.rem) begin
         key_in   = right_key;
         valid_in = right_valid;
      end else if (ctl.scan) begin
         match_in = valid_ff && (key_ff == ctl.key);
      end else begin
         // With no operation the slot holds its contents.
      end
   end

   // Control bits are reset; the key slot is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

FILE: sv/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Keeps up to CAPACITY signed keys in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. The
//   command is insert, remove smallest, or scan for a key. Busy stays low, so
//   a new request may be issued in every cycle.
//   Each request gives exactly one response, shown for one cycle with
//   rsp_strobe high in the cycle after the request was taken. It reports the
//   scan result, a status code, the key count and the smallest key after the
//   operation. An insert into a full queue is dropped with status full; a
//   remove on an empty queue leaves it unchanged with status empty.
//   Throughput is one request per cycle: every cell compares and shifts in
//   parallel with its neighbors, and the scan match bits are registered per
//   cell and reduced when the response is shown.
//   Reset empties the queue; no clearing pass is needed.
//   The receiver cannot stall responses; none are ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top #(
   parameter int CAPACITY = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_command,
   input  wire logic signed [spq_pkg::KEY_W-1:0]   req_key,
   output logic                                    rsp_strobe,
   output logic                                    rsp_found,
   output logic [1:0]                              rsp_status,
   output logic [spq_pkg::COUNT_W-1:0]             rsp_count,
   output logic                                    rsp_front_valid,
   output logic signed [spq_pkg::KEY_W-1:0]        rsp_front_key
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [KEY_W-1:0]  cell_key   [CAPACITY];
   logic              cell_valid [CAPACITY];
   logic [CAPACITY-1:0] cell_take;
   logic [CAPACITY-1:0] cell_match;

   logic             accept;
   cmd_type          cmd;
   logic             is_full;
   logic             is_empty;
   ctl_type          ctl;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             strobe_ff;
   status_type       status_ff;
   status_type       status_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign cmd      = cmd_type'(req_command);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // Decode the request into the operation broadcast to the chain.
   always_comb begin
      ctl.ins   = 1'b0;
      ctl.rem   = 1'b0;
      ctl.scan  = 1'b0;
      ctl.key   = req_key;
      status_in = ST_OK;
      count_in  = count_ff;
      if (accept) begin
         unique case (cmd)
            CMD_INSERT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.ins  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctl.rem  = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_SCAN: begin
               ctl.scan = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Chain of cells, each wired to its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] lkey;
      logic             lvalid;
      logic             ltake;
      logic [KEY_W-1:0] rkey;
      logic             rvalid;

      if (i == 0) begin : g_first
         assign lkey   = '0;
         assign lvalid = 1'b1;
         assign ltake  = 1'b0;
      end else begin : g_mid
         assign lkey   = cell_key[i-1];
         assign lvalid = cell_valid[i-1];
         assign ltake  = cell_take[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rkey   = '0;
         assign rvalid = 1'b0;
      end else begin : g_inner
         assign rkey   = cell_key[i+1];
         assign rvalid = cell_valid[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_key    (lkey),
         .left_valid  (lvalid),
         .left_take   (ltake),
         .right_key   (rkey),
         .right_valid (rvalid),
         .key_ff      (cell_key[i]),
         .valid_ff    (cell_valid[i]),
         .take        (cell_take[i]),
         .match_ff    (cell_match[i])
      );
   end

   // Occupancy and response control.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
         status_ff <= status_in;
      end
   end

   // Response fields, taken from the registered queue state.
   assign rsp_strobe      = strobe_ff;
   assign rsp_found       = |cell_match;
   assign rsp_status      = status_ff;
   assign rsp_count       = COUNT_W'(count_ff);
   assign rsp_front_valid = cell_valid[0];
   assign rsp_front_key   = cell_valid[0] ? cell_key[0] : '0;

endmodule

`default_nettype wire

FILE: dv/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches the request and response ports of the queue, keeps its own sorted
// copy of the stored keys, works out the response that each accepted request
// must give and compares every response field with the oldest one waiting.
// ----------------------------------------------------------------------------

module sorted_priority_queue_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [1:0]                            req_command,
   input  logic signed [spq_pkg::KEY_W-1:0]      req_key,
   input  logic                                  rsp_strobe,
   input  logic                                  rsp_found,
   input  logic [1:0]                            rsp_status,
   input  logic [spq_pkg::COUNT_W-1:0]           rsp_count,
   input  logic                                  rsp_front_valid,
   input  logic signed [spq_pkg::KEY_W-1:0]      rsp_front_key,
   output int                                    fail_count,
   output int                                    pending_count
);

   import spq_pkg::*;

   // One response as the queue must report it.
   typedef struct packed {
      logic                     found;
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic                     front_valid;
      logic signed [KEY_W-1:0]  front_key;
   } queue_report_type;

   // Shadow copy of the queue contents, ascending.
   logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
   int                      shadow_fill;

   // Responses owed by the queue, oldest first.
   queue_report_type        owed_reports [$];
   int                      mismatches = 0;

   assign fail_count = mismatches;

   initial begin
      shadow_fill   = 0;
      pending_count <= 0;
   end

   // Applies one request to the shadow queue and returns the report it gives.
   function automatic queue_report_type apply_request(logic [1:0] command,
                                                      logic signed [KEY_W-1:0] key);
      queue_report_type report;
      int               pos;
      report        = '0;
      report.status = ST_OK;
      case (cmd_type'(command))
         CMD_INSERT: begin
            if (shadow_fill >= CAPACITY) begin
               report.status = ST_FULL;
            end else begin
               // A new key goes ahead of any equal keys already stored.
               pos = 0;
               while (pos < shadow_fill && shadow_keys[pos] < key) pos++;
               for (int i = shadow_fill; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
               shadow_keys[pos] = key;
               shadow_fill++;
            end
         end
         CMD_REMOVE: begin
            if (shadow_fill == 0) begin
               report.status = ST_EMPTY;
            end else begin
               for (int i = 1; i < shadow_fill; i++) shadow_keys[i-1] = shadow_keys[i];
               shadow_fill--;
            end
         end
         CMD_SCAN: begin
            for (int i = 0; i < shadow_fill; i++) begin
               if (shadow_keys[i] == key) report.found = 1'b1;
            end
         end
         default: begin
            // The unused command code leaves the queue as it is.
         end
      endcase
      report.count       = COUNT_W'(shadow_fill);
      report.front_valid = (shadow_fill != 0);
      report.front_key   = (shadow_fill != 0) ? shadow_keys[0] : '0;
      return report;
   endfunction

   // Reports one field that differs from its expected value.
   task automatic compare_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         mismatches++;
      end
   endtask

   // Check responses first, then record the request taken at this edge.
   always @(posedge clock) begin : watch_ports
      queue_report_type oldest;
      if (reset) begin
         shadow_fill = 0;
         owed_reports.delete();
      end else begin
         if (rsp_strobe) begin
            if (owed_reports.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               oldest = owed_reports.pop_front();
               compare_field("found", oldest.found, rsp_found);
               compare_field("status", oldest.status, rsp_status);
               compare_field("count", oldest.count, rsp_count);
               compare_field("front_valid", oldest.front_valid, rsp_front_valid);
               compare_field("front_key", oldest.front_key, rsp_front_key);
            end
         end
         if (start && !busy) begin
            owed_reports = {owed_reports, apply_request(req_command, req_key)};
         end
      end
      pending_count <= owed_reports.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives directed and random requests into the queue in bursts with random
// gaps, filling it past full and draining it past empty, while the checker
// beside the queue predicts and compares every response.
// ----------------------------------------------------------------------------

module testbench;

   import spq_pkg::*;

   localparam int          CAPACITY      = 64;
   localparam int          RANDOM_ITEMS  = 1600;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          POOL_SIZE     = 12;
   localparam logic [1:0]  CMD_NOOP      = 2'd3;

   // Mixes of commands that steer the queue toward full, empty or neither.
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_command;
   logic signed [KEY_W-1:0]     req_key;
   logic                        rsp_strobe;
   logic                        rsp_found;
   logic [1:0]                  rsp_status;
   logic [COUNT_W-1:0]          rsp_count;
   logic                        rsp_front_valid;
   logic signed [KEY_W-1:0]     rsp_front_key;
   int                          fail_count;
   int                          pending_count;
   int                          cycle_count = 0;
   int                          burst_left  = 0;
   logic signed [KEY_W-1:0]     key_pool [POOL_SIZE];

   sorted_priority_queue_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_key(req_key),
      .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_front_valid(rsp_front_valid),
      .rsp_front_key(rsp_front_key)
   );

   sorted_priority_queue_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_key(req_key),
      .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_front_valid(rsp_front_valid),
      .rsp_front_key(rsp_front_key),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always #4 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Sends one request, opening a new burst after a random gap when the last
   // burst is used up.
   task automatic issue_request(logic [1:0] command, logic signed [KEY_W-1:0] key);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start       <= 1'b1;
      req_command <= command;
      req_key     <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds requests off until every outstanding response has come back.
   task automatic wait_for_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Draws a key: often a pooled one so that duplicates and scan hits occur,
   // sometimes an extreme value, otherwise a fully random one.
   function automatic logic signed [KEY_W-1:0] pick_key();
      int                      roll;
      logic signed [KEY_W-1:0] key;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 55) begin
         case ($urandom_range(0, 5))
            0:       key = 32'sh7FFFFFFF;
            1:       key = 32'sh80000000;
            2:       key = 32'sh7FFFFFFE;
            3:       key = 32'sh80000001;
            4:       key = -32'sd1;
            default: key = 32'sd0;
         endcase
      end else begin
         key = $urandom;
         if ($urandom_range(0, 3) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = key;
      end
      return key;
   endfunction

   // Draws a command according to the current mix.
   function automatic logic [1:0] pick_command(mix_type mix);
      int roll;
      int insert_pct;
      int remove_pct;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin insert_pct = 85; remove_pct = 8;  end
         MIX_DRAIN: begin insert_pct = 12; remove_pct = 76; end
         default:   begin insert_pct = 40; remove_pct = 30; end
      endcase
      if (roll < 3) return CMD_NOOP;
      if (roll < 3 + insert_pct) return CMD_INSERT;
      if (roll < 3 + insert_pct + remove_pct) return CMD_REMOVE;
      return CMD_SCAN;
   endfunction

   initial begin
      int          items_sent;
      int          segment_len;
      bit          paused;
      mix_type     mix;
      logic [1:0]  command;
      reset       = 1'b1;
      start       = 1'b0;
      req_command = '0;
      req_key     = '0;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extreme keys, duplicates, scan hit and miss, the unused
      // command, and removes past empty.
      issue_request(CMD_INSERT, 32'sh7FFFFFFF);
      issue_request(CMD_SCAN,   32'sh7FFFFFFF);
      issue_request(CMD_INSERT, 32'sh80000000);
      issue_request(CMD_INSERT, 32'sd0);
      issue_request(CMD_INSERT, 32'sd0);
      issue_request(CMD_SCAN,   32'sd0);
      issue_request(CMD_SCAN,   32'sd5);
      issue_request(CMD_INSERT, -32'sd1);
      issue_request(CMD_SCAN,   32'sh80000000);
      issue_request(CMD_NOOP,   -32'sd1);
      repeat (5) issue_request(CMD_REMOVE, 32'sd0);
      issue_request(CMD_REMOVE, -32'sd1);
      issue_request(CMD_SCAN,   32'sd0);
      issue_request(CMD_NOOP,   32'sd0);
      issue_request(CMD_INSERT, 32'sh55555555);
      issue_request(CMD_INSERT, 32'shAAAAAAAA);
      issue_request(CMD_SCAN,   32'shAAAAAAAA);
      issue_request(CMD_REMOVE, 32'sd0);
      issue_request(CMD_REMOVE, 32'sd0);
      wait_for_responses();

      // Random part: segments of one mix long enough to reach full or empty.
      items_sent = 0;
      paused     = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         segment_len = $urandom_range(60, 160);
         mix         = mix_type'($urandom_range(0, 2));
         for (int k = 0; k < segment_len && items_sent < RANDOM_ITEMS; k++) begin
            command = pick_command(mix);
            issue_request(command, (command == CMD_REMOVE) ? $urandom : pick_key());
            if (command != CMD_NOOP) items_sent++;
         end
         if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
            wait_for_responses();
            paused = 1'b1;
         end
      end

      // Let the last responses come back, then give the verdict.
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_top.sv
dv/sorted_priority_queue_checker.sv
dv/testbench.sv
